[rtl/hwd_pkg.sv]
// Package: types, constants and codes shared by the tree-walk decoder files.
`default_nettype none
package hwd_pkg;

  // Tree size and field widths
  localparam int SYMBOL_COUNT = 256;
  localparam int NODE_DEPTH   = 2 * SYMBOL_COUNT - 1;
  localparam int NODE_AW      = 9;
  localparam int SYM_W        = 8;
  localparam int COUNT_BITS   = 32;
  localparam int BYTE_BITS    = 8;
  localparam int BIT_CNT_W    = $clog2(BYTE_BITS + 1);
  localparam int BUF_DEPTH    = BYTE_BITS;
  localparam int BUF_AW       = $clog2(BUF_DEPTH);
  localparam int BUF_CNT_W    = $clog2(BUF_DEPTH + 1);
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 32;
  localparam int PAD_W        = 3;

  localparam logic [NODE_AW-1:0] NO_CHILD = '1;

  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_START = 2'd1,
    MODE_BYTE  = 2'd2
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EXPECTED = 2'd0,
    REG_PAD      = 2'd1,
    REG_ROOT     = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_RUN    = 2'd0,
    ST_DONE   = 2'd1,
    ST_BROKEN = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_STEP,
    S_CHECK,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic [NODE_AW-1:0] left;
    logic [NODE_AW-1:0] right;
    logic [SYM_W-1:0]   sym;
  } node_t;

  // Control from the walker to the result buffer
  typedef struct packed {
    logic             clear;
    logic             push;
    logic             pop;
    logic [SYM_W-1:0] sym;
  } buf_ctl_t;

endpackage
`default_nettype wire

[rtl/hwd_ifs.sv]
// Interfaces: input item, result and configuration write channels.
`default_nettype none
interface hwd_in_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       mode;
  logic [hwd_pkg::NODE_AW-1:0]      node_index;
  logic [hwd_pkg::NODE_AW-1:0]      left_child;
  logic [hwd_pkg::NODE_AW-1:0]      right_child;
  logic [hwd_pkg::SYM_W-1:0]        leaf_symbol;
  logic [hwd_pkg::BYTE_BITS-1:0]    data_byte;
  logic                             final_byte;

  modport source (output valid, mode, node_index, left_child, right_child, leaf_symbol,
                  data_byte, final_byte, input ready);
  modport sink (input valid, mode, node_index, left_child, right_child, leaf_symbol,
                data_byte, final_byte, output ready);
endinterface

interface hwd_out_if;
  logic                      valid;
  logic                      ready;
  logic [hwd_pkg::SYM_W-1:0] symbol;
  logic                      symbol_valid;
  logic                      last;
  logic [1:0]                status;

  modport source (output valid, symbol, symbol_valid, last, status, input ready);
  modport sink (input valid, symbol, symbol_valid, last, status, output ready);
endinterface

interface hwd_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [hwd_pkg::CFG_IDX_W-1:0]      index;
  logic [hwd_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[rtl/hwd_node_ram.sv]
// Node store: single-port write, one registered read port.
`default_nettype none
module hwd_node_ram (
  input  wire logic                        clk,
  input  wire logic                        wr_en,
  input  wire logic [hwd_pkg::NODE_AW-1:0] wr_addr,
  input  wire hwd_pkg::node_t              wr_data,
  input  wire logic                        rd_en,
  input  wire logic [hwd_pkg::NODE_AW-1:0] rd_addr,
  output hwd_pkg::node_t                   rd_data
);

  hwd_pkg::node_t mem [hwd_pkg::NODE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

[rtl/hwd_sym_buf.sv]
// Result buffer: holds the symbols of one byte until the item is finished.
`default_nettype none
module hwd_sym_buf (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire hwd_pkg::buf_ctl_t         ctl,
  output logic [hwd_pkg::SYM_W-1:0]      symbol,
  output logic                           symbol_valid,
  output logic                           last
);

  logic [hwd_pkg::SYM_W-1:0]     syms [hwd_pkg::BUF_DEPTH];
  logic [hwd_pkg::BUF_CNT_W-1:0] fill;
  logic [hwd_pkg::BUF_AW-1:0]    rd_idx;

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      syms[fill[hwd_pkg::BUF_AW-1:0]] <= ctl.sym;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      fill   <= '0;
      rd_idx <= '0;
    end else begin
      if (ctl.push) begin
        fill <= fill + 1'b1;
      end
      if (ctl.pop) begin
        rd_idx <= rd_idx + 1'b1;
      end
    end
  end

  // An empty buffer still yields one result: no symbol, last set
  always_comb begin
    symbol_valid = (fill != '0);
    symbol       = symbol_valid ? syms[rd_idx] : '0;
    last         = !symbol_valid || ({1'b0, rd_idx} == fill - 1'b1);
  end

endmodule
`default_nettype wire

[rtl/huffman_tree_walk_decoder_core.sv]
// Top level: Huffman tree-walk decoder with node store, bit walker and result buffer.
//
//  channel | dir | modport | payload
//  --------+-----+---------+-------------------------------------------------------
//  inp     | in  | sink    | mode, node_index, left/right_child, leaf_symbol,
//          |     |         | data_byte, final_byte
//  outp    | out | source  | symbol, symbol_valid, last, status
//  cfg     | in  | sink    | index (0 expected_symbols, 1 pad_bits, 2 root_node), data
//
//  Flow: one word at a time. Load, start and unknown words pass intake and give
//    one result. A byte word passes intake, a fetch of the current node, then per
//    walked bit one node store read to fetch the child and one step to test it for
//    a leaf, and a closing step, then emits its results one by one; the serial
//    chain of dependent node store reads sets the pace of a byte word.
//  Reset: rst (synchronous) clears walk position, count, flags and config.
//    The node store has no reset; nodes must be loaded before use.
//  Stalls: inp.ready is low from acceptance until the last result is taken;
//    results wait in the buffer for as long as outp.ready stays low.
`default_nettype none
module huffman_tree_walk_decoder_core (
  input wire logic   clk,
  input wire logic   rst,
  hwd_in_if.sink     inp,
  hwd_out_if.source  outp,
  hwd_cfg_if.sink    cfg
);

  // Config registers
  logic [hwd_pkg::COUNT_BITS-1:0] expected;
  logic [hwd_pkg::PAD_W-1:0]      pad;
  logic [hwd_pkg::NODE_AW-1:0]    root;

  // Walk state
  hwd_pkg::state_t                state, state_next;
  logic [hwd_pkg::NODE_AW-1:0]    pos;
  logic [hwd_pkg::COUNT_BITS-1:0] count;
  logic                           broken;
  logic                           complete;
  logic [hwd_pkg::BYTE_BITS-1:0]  shreg;     // data bits, MSB shifts out first
  logic [hwd_pkg::BIT_CNT_W-1:0]  bits_left;

  // Node store ports
  logic                           ram_wr;
  hwd_pkg::node_t                 ram_wdata;
  logic                           ram_rd;
  logic [hwd_pkg::NODE_AW-1:0]    ram_raddr;
  hwd_pkg::node_t                 node_q;

  hwd_pkg::buf_ctl_t              buf_ctl;

  logic                           in_acc;
  logic                           out_acc;
  logic [hwd_pkg::NODE_AW-1:0]    child;
  logic                           child_bad;
  logic                           pos_bad;
  logic                           root_ok;
  logic                           is_leaf;
  logic [hwd_pkg::COUNT_BITS-1:0] count_inc;
  logic                           stop;

  assign in_acc    = inp.valid && inp.ready;
  assign out_acc   = outp.valid && outp.ready;
  assign cfg.ready = 1'b1;

  // Bit 1 takes the right child, bit 0 the left
  assign child     = shreg[hwd_pkg::BYTE_BITS-1] ? node_q.right : node_q.left;
  assign child_bad = (child == hwd_pkg::NO_CHILD) ||
                     (child >= hwd_pkg::NODE_AW'(hwd_pkg::NODE_DEPTH));
  assign pos_bad   = (pos >= hwd_pkg::NODE_AW'(hwd_pkg::NODE_DEPTH));
  assign root_ok   = (root < hwd_pkg::NODE_AW'(hwd_pkg::NODE_DEPTH));
  assign is_leaf   = (node_q.left == hwd_pkg::NO_CHILD) && (node_q.right == hwd_pkg::NO_CHILD);
  assign count_inc = count + 1'b1;
  assign stop      = broken || complete || (bits_left == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      expected <= '0;
      pad      <= '0;
      root     <= '0;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        hwd_pkg::REG_EXPECTED: expected <= cfg.data;
        hwd_pkg::REG_PAD:      pad      <= cfg.data[hwd_pkg::PAD_W-1:0];
        hwd_pkg::REG_ROOT:     root     <= cfg.data[hwd_pkg::NODE_AW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hwd_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, handshakes, node store and buffer control
  always_comb begin
    state_next   = state;
    inp.ready    = 1'b0;
    outp.valid   = 1'b0;
    ram_wr       = 1'b0;
    ram_wdata    = '{left: inp.left_child, right: inp.right_child, sym: inp.leaf_symbol};
    ram_rd       = 1'b0;
    ram_raddr    = pos;
    buf_ctl      = '{clear: 1'b0, push: 1'b0, pop: 1'b0, sym: node_q.sym};
    case (state)
      hwd_pkg::S_IDLE: begin
        inp.ready = 1'b1;
        if (in_acc) begin
          buf_ctl.clear = 1'b1;
          case (inp.mode)
            hwd_pkg::MODE_LOAD: begin
              ram_wr     = (inp.node_index < hwd_pkg::NODE_AW'(hwd_pkg::NODE_DEPTH));
              state_next = hwd_pkg::S_EMIT;
            end
            hwd_pkg::MODE_BYTE: state_next = hwd_pkg::S_FETCH;
            default:            state_next = hwd_pkg::S_EMIT;
          endcase
        end
      end
      hwd_pkg::S_FETCH: begin
        ram_rd     = !pos_bad;
        state_next = hwd_pkg::S_STEP;
      end
      hwd_pkg::S_STEP: begin
        if (stop || pos_bad || child_bad) begin
          state_next = hwd_pkg::S_EMIT;
        end else begin
          ram_rd     = 1'b1;
          ram_raddr  = child;
          state_next = hwd_pkg::S_CHECK;
        end
      end
      hwd_pkg::S_CHECK: begin
        if (is_leaf) begin
          buf_ctl.push = 1'b1;
          ram_rd       = root_ok;
          ram_raddr    = root;
        end
        state_next = hwd_pkg::S_STEP;
      end
      hwd_pkg::S_EMIT: begin
        outp.valid = 1'b1;
        if (out_acc) begin
          buf_ctl.pop = 1'b1;
          if (outp.last) begin
            state_next = hwd_pkg::S_IDLE;
          end
        end
      end
      default: state_next = hwd_pkg::S_IDLE;
    endcase
  end

  // Walk datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      count    <= '0;
      broken   <= 1'b0;
      complete <= 1'b0;
    end else begin
      case (state)
        hwd_pkg::S_IDLE: begin
          if (in_acc && inp.mode == hwd_pkg::MODE_START) begin
            pos      <= root;
            count    <= '0;
            broken   <= 1'b0;
            complete <= 1'b0;
          end
        end
        hwd_pkg::S_STEP: begin
          if (!stop) begin
            if (pos_bad || child_bad) begin
              broken <= 1'b1;
            end else begin
              pos <= child;
            end
          end
        end
        hwd_pkg::S_CHECK: begin
          if (is_leaf) begin
            pos   <= root;
            count <= count_inc;
            if (expected != '0 && count_inc == expected) begin
              complete <= 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Bit shifter and bit budget; payload only
  always_ff @(posedge clk) begin
    if (state == hwd_pkg::S_IDLE && in_acc) begin
      shreg     <= inp.data_byte;
      bits_left <= inp.final_byte
                   ? hwd_pkg::BIT_CNT_W'(hwd_pkg::BYTE_BITS) - hwd_pkg::BIT_CNT_W'(pad)
                   : hwd_pkg::BIT_CNT_W'(hwd_pkg::BYTE_BITS);
    end else if (state == hwd_pkg::S_STEP && !(stop || pos_bad || child_bad)) begin
      shreg     <= {shreg[hwd_pkg::BYTE_BITS-2:0], 1'b0};
      bits_left <= bits_left - 1'b1;
    end
  end

  hwd_node_ram u_ram (
    .clk     (clk),
    .wr_en   (ram_wr),
    .wr_addr (inp.node_index),
    .wr_data (ram_wdata),
    .rd_en   (ram_rd),
    .rd_addr (ram_raddr),
    .rd_data (node_q)
  );

  hwd_sym_buf u_buf (
    .clk          (clk),
    .rst          (rst),
    .ctl          (buf_ctl),
    .symbol       (outp.symbol),
    .symbol_valid (outp.symbol_valid),
    .last         (outp.last)
  );

  // Status as it stands after the whole word
  assign outp.status = broken   ? hwd_pkg::ST_BROKEN :
                       complete ? hwd_pkg::ST_DONE   : hwd_pkg::ST_RUN;

endmodule
`default_nettype wire

[rtl/hwd_checker.sv]
// Port checker for the decoder, bound to the top level.
`default_nettype none
module hwd_checker (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      in_ready,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire logic [hwd_pkg::SYM_W-1:0] out_symbol,
  input wire logic                      out_symbol_valid,
  input wire logic                      out_last,
  input wire logic [1:0]                out_status
);

  // One word in flight: no intake while results are pending
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(out_valid && in_ready))
    else $error("input ready while results pending");

  // An empty result is the only and last one and carries no symbol
  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_symbol_valid |-> out_last && out_symbol == '0)
    else $error("empty result malformed");

  // All results of one word share its final status
  a_status_same: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_last |=> out_valid && $stable(out_status))
    else $error("status changed within a word");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result offered right after reset");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_status == hwd_pkg::ST_RUN || out_status == hwd_pkg::ST_DONE ||
                  out_status == hwd_pkg::ST_BROKEN)
    else $error("bad status code");

endmodule

bind huffman_tree_walk_decoder_core hwd_checker u_chk (
  .clk              (clk),
  .rst              (rst),
  .in_ready         (inp.ready),
  .out_valid        (outp.valid),
  .out_ready        (outp.ready),
  .out_symbol       (outp.symbol),
  .out_symbol_valid (outp.symbol_valid),
  .out_last         (outp.last),
  .out_status       (outp.status)
);
`default_nettype wire

[test/hwd_decode_check.sv]
// Decode checker: mirrors the tree walk, queues expected result words and compares the output.
`timescale 1ns / 1ps
module hwd_decode_check (
  input  logic        clk,
  input  logic        rst,
  hwd_in_if           inp,
  hwd_out_if          outp,
  hwd_cfg_if          cfg,
  output int unsigned fail_count,
  output int unsigned pending,
  output int unsigned words_out,
  output int unsigned symbols_out
);

  typedef struct packed {
    logic [hwd_pkg::SYM_W-1:0] symbol;
    logic                      symbol_valid;
    logic                      last;
    hwd_pkg::status_t          status;
  } result_word_t;

  hwd_pkg::node_t                 tree_mem [hwd_pkg::NODE_DEPTH];
  logic [hwd_pkg::NODE_AW-1:0]    walk_at;
  logic [hwd_pkg::NODE_AW-1:0]    root_at;
  logic [hwd_pkg::COUNT_BITS-1:0] sym_total;
  logic [hwd_pkg::CFG_DATA_W-1:0] sym_limit;
  logic [hwd_pkg::PAD_W-1:0]      pad_cnt;
  logic                           stream_broken;
  logic                           stream_done;
  result_word_t                   expected_q [$];
  result_word_t                   head;
  int unsigned                    fails = 0;
  int unsigned                    n_words = 0;
  int unsigned                    n_syms = 0;

  // Walk one accepted input word and queue the result words it should produce.
  task automatic decode_word();
    logic [hwd_pkg::SYM_W-1:0]   syms [$];
    hwd_pkg::node_t              cur;
    logic [hwd_pkg::NODE_AW-1:0] nxt;
    int                          nbits;
    hwd_pkg::status_t            st;
    case (inp.mode)
      hwd_pkg::MODE_LOAD: begin
        if (inp.node_index < hwd_pkg::NODE_DEPTH)
          tree_mem[inp.node_index] = '{left: inp.left_child, right: inp.right_child,
                                       sym: inp.leaf_symbol};
      end
      hwd_pkg::MODE_START: begin
        walk_at       = root_at;
        sym_total     = '0;
        stream_broken = 1'b0;
        stream_done   = 1'b0;
      end
      hwd_pkg::MODE_BYTE: begin
        nbits = inp.final_byte ? hwd_pkg::BYTE_BITS - int'(pad_cnt) : hwd_pkg::BYTE_BITS;
        for (int b = 0; b < nbits; b++) begin
          if (stream_broken || stream_done) break;
          if (walk_at < hwd_pkg::NODE_DEPTH) cur = tree_mem[walk_at];
          else cur = '{left: hwd_pkg::NO_CHILD, right: hwd_pkg::NO_CHILD, sym: '0};
          nxt = inp.data_byte[hwd_pkg::BYTE_BITS-1-b] ? cur.right : cur.left;
          if (nxt == hwd_pkg::NO_CHILD || nxt >= hwd_pkg::NODE_DEPTH) begin
            stream_broken = 1'b1;
            break;
          end
          walk_at = nxt;
          cur     = tree_mem[nxt];
          if (cur.left == hwd_pkg::NO_CHILD && cur.right == hwd_pkg::NO_CHILD) begin
            syms.insert(syms.size(), cur.sym);
            walk_at   = root_at;
            sym_total = sym_total + 1'b1;
            if (sym_limit != 0 && sym_total == sym_limit) stream_done = 1'b1;
          end
        end
      end
      default: ;
    endcase
    st = stream_broken ? hwd_pkg::ST_BROKEN :
         (stream_done ? hwd_pkg::ST_DONE : hwd_pkg::ST_RUN);
    if (syms.size() == 0)
      expected_q.insert(expected_q.size(),
                        result_word_t'{symbol: '0, symbol_valid: 1'b0, last: 1'b1, status: st});
    else
      foreach (syms[k])
        expected_q.insert(expected_q.size(),
                          result_word_t'{symbol: syms[k], symbol_valid: 1'b1,
                                         last: (k == syms.size() - 1), status: st});
  endtask

  task automatic check_word();
    n_words++;
    if (outp.symbol_valid) n_syms++;
    if (expected_q.size() == 0) begin
      $error("result word with nothing expected: symbol %0h valid %0b last %0b status %0d",
             outp.symbol, outp.symbol_valid, outp.last, outp.status);
      fails++;
    end else begin
      head = expected_q.pop_front();
      if (outp.symbol !== head.symbol) begin
        $error("symbol: expected %0h, got %0h", head.symbol, outp.symbol);
        fails++;
      end
      if (outp.symbol_valid !== head.symbol_valid) begin
        $error("symbol_valid: expected %0b, got %0b", head.symbol_valid, outp.symbol_valid);
        fails++;
      end
      if (outp.last !== head.last) begin
        $error("last: expected %0b, got %0b", head.last, outp.last);
        fails++;
      end
      if (outp.status !== head.status) begin
        $error("status: expected %0d, got %0d", head.status, outp.status);
        fails++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      walk_at       = '0;
      root_at       = '0;
      sym_total     = '0;
      sym_limit     = '0;
      pad_cnt       = '0;
      stream_broken = 1'b0;
      stream_done   = 1'b0;
      expected_q.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          hwd_pkg::REG_EXPECTED: sym_limit = cfg.data;
          hwd_pkg::REG_PAD:      pad_cnt   = cfg.data[hwd_pkg::PAD_W-1:0];
          hwd_pkg::REG_ROOT:     root_at   = cfg.data[hwd_pkg::NODE_AW-1:0];
          default: ;
        endcase
      end
      if (inp.valid && inp.ready) decode_word();
      if (outp.valid && outp.ready) check_word();
    end
    fail_count  <= fails;
    pending     <= expected_q.size();
    words_out   <= n_words;
    symbols_out <= n_syms;
  end

endmodule

[test/huffman_tree_walk_decoder_core_tb.sv]
// Testbench top: drives tree loads, stream starts and data bytes into the decoder.
`timescale 1ns / 1ps
module huffman_tree_walk_decoder_core_tb;

  // Mode code the block must ignore
  localparam logic [1:0]                  MODE_UNUSED  = 2'd3;
  // Load address one past the store, must be dropped
  localparam logic [hwd_pkg::NODE_AW-1:0] OUT_OF_STORE =
    hwd_pkg::NODE_AW'(hwd_pkg::NODE_DEPTH);
  localparam int TARGET_WORDS = 330;
  localparam int HOLD_CYCLES  = 300;  // long receiver hold-off
  localparam int SETTLE       = 24;   // pause once all results are back
  localparam int DRAIN_LIMIT  = 20000;

  logic clk = 1'b0;
  logic rst;

  hwd_in_if  inp_ch ();
  hwd_out_if out_ch ();
  hwd_cfg_if cfg_ch ();

  int unsigned fail_count;
  int unsigned pending;
  int unsigned words_out;
  int unsigned symbols_out;

  // Traffic shaping, set per phase by the stimulus process
  int          idle_pct = 0;
  int          stall_pct = 0;
  int unsigned hold_tickets = 0;

  // Which node store entries hold a node; walks must never touch any other entry
  bit node_loaded [hwd_pkg::NODE_DEPTH];
  int words_sent = 0;
  int streams = 0;

  huffman_tree_walk_decoder_core dut (
    .clk  (clk),
    .rst  (rst),
    .inp  (inp_ch),
    .outp (out_ch),
    .cfg  (cfg_ch)
  );

  hwd_decode_check decode_check (
    .clk         (clk),
    .rst         (rst),
    .inp         (inp_ch),
    .outp        (out_ch),
    .cfg         (cfg_ch),
    .fail_count  (fail_count),
    .pending     (pending),
    .words_out   (words_out),
    .symbols_out (symbols_out)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop in case the handshake locks up
  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Result side: random stalls per phase, plus a long hold-off whenever a ticket is
  // issued. The hold-off lets the block fill up so it has to stall its input.
  initial begin
    int unsigned hold_served;
    int          hold_left;
    hold_served = 0;
    hold_left   = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        out_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (hold_served != hold_tickets) begin
        out_ch.ready <= 1'b0;
        hold_served++;
        hold_left = HOLD_CYCLES;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Offer one word; valid is left high so back-to-back words need no extra edge.
  task automatic send_word(input logic [1:0] mode, input logic [hwd_pkg::NODE_AW-1:0] idx,
                           input logic [hwd_pkg::NODE_AW-1:0] lc,
                           input logic [hwd_pkg::NODE_AW-1:0] rc,
                           input logic [hwd_pkg::SYM_W-1:0] sym, input logic [7:0] dbyte,
                           input logic fin);
    while ($urandom_range(99) < idle_pct) begin
      inp_ch.valid <= 1'b0;
      @(posedge clk);
    end
    inp_ch.valid       <= 1'b1;
    inp_ch.mode        <= mode;
    inp_ch.node_index  <= idx;
    inp_ch.left_child  <= lc;
    inp_ch.right_child <= rc;
    inp_ch.leaf_symbol <= sym;
    inp_ch.data_byte   <= dbyte;
    inp_ch.final_byte  <= fin;
    @(posedge clk);
    while (!inp_ch.ready) @(posedge clk);
    words_sent++;
    if (mode == hwd_pkg::MODE_LOAD && idx < hwd_pkg::NODE_DEPTH) node_loaded[idx] = 1'b1;
  endtask

  // Unused fields get random values so every input bit toggles.
  task automatic send_load(input logic [hwd_pkg::NODE_AW-1:0] idx,
                           input logic [hwd_pkg::NODE_AW-1:0] lc,
                           input logic [hwd_pkg::NODE_AW-1:0] rc,
                           input logic [hwd_pkg::SYM_W-1:0] sym);
    send_word(hwd_pkg::MODE_LOAD, idx, lc, rc, sym, 8'($urandom_range(255)),
              1'($urandom_range(1)));
  endtask

  task automatic send_byte(input logic [7:0] dbyte, input logic fin);
    send_word(hwd_pkg::MODE_BYTE, 9'($urandom_range(511)), 9'($urandom_range(511)),
              9'($urandom_range(511)), 8'($urandom_range(255)), dbyte, fin);
  endtask

  task automatic send_start();
    send_word(hwd_pkg::MODE_START, 9'($urandom_range(511)), 9'($urandom_range(511)),
              9'($urandom_range(511)), 8'($urandom_range(255)), 8'($urandom_range(255)),
              1'($urandom_range(1)));
  endtask

  // Drop valid and wait until every expected result word is back, then let the
  // walker settle before touching a register.
  task automatic wait_idle();
    inp_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input hwd_pkg::reg_idx_t idx,
                           input logic [hwd_pkg::CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [hwd_pkg::NODE_AW-1:0] pick_loaded();
    logic [hwd_pkg::NODE_AW-1:0] n;
    do n = hwd_pkg::NODE_AW'($urandom_range(hwd_pkg::NODE_DEPTH - 1));
    while (!node_loaded[n]);
    return n;
  endfunction

  // Child pointers only ever go to loaded nodes, or to the no-child marker
  function automatic logic [hwd_pkg::NODE_AW-1:0] pick_child();
    if ($urandom_range(3) == 0) return hwd_pkg::NO_CHILD;
    return pick_loaded();
  endfunction

  // Load a full code tree with the given leaf count in a random slice of the store.
  // Leaves go first, then parents joining two random subtrees; the last node is root.
  task automatic build_tree(input int leaves, output logic [hwd_pkg::NODE_AW-1:0] root);
    logic [hwd_pkg::NODE_AW-1:0] pool [$];
    logic [hwd_pkg::NODE_AW-1:0] lc;
    logic [hwd_pkg::NODE_AW-1:0] rc;
    logic [hwd_pkg::NODE_AW-1:0] slot;
    int                          pick;
    slot = hwd_pkg::NODE_AW'($urandom_range(hwd_pkg::NODE_DEPTH + 1 - 2 * leaves, 0));
    repeat (leaves) begin
      send_load(slot, hwd_pkg::NO_CHILD, hwd_pkg::NO_CHILD, 8'($urandom_range(255)));
      pool.insert(pool.size(), slot);
      slot++;
    end
    while (pool.size() > 1) begin
      pick = $urandom_range(pool.size() - 1);
      lc   = pool[pick];
      pool.delete(pick);
      pick = $urandom_range(pool.size() - 1);
      rc   = pool[pick];
      pool.delete(pick);
      send_load(slot, lc, rc, 8'($urandom_range(255)));
      pool.insert(pool.size(), slot);
      slot++;
    end
    root = pool[0];
  endtask

  initial begin
    logic [hwd_pkg::NODE_AW-1:0] tree_root;
    int                          nbytes;
    int                          noise;
    int                          guard;

    rst                <= 1'b1;
    inp_ch.valid       <= 1'b0;
    inp_ch.mode        <= hwd_pkg::MODE_LOAD;
    inp_ch.node_index  <= '0;
    inp_ch.left_child  <= '0;
    inp_ch.right_child <= '0;
    inp_ch.leaf_symbol <= '0;
    inp_ch.data_byte   <= '0;
    inp_ch.final_byte  <= 1'b0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.index       <= hwd_pkg::REG_EXPECTED;
    cfg_ch.data        <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---- Directed part ----
    // Small tree at the bottom of the store, root at 0:
    //   0 -> 8'h00, 10 -> 8'hFF, 11 -> 8'h5A
    send_load(9'd1, hwd_pkg::NO_CHILD, hwd_pkg::NO_CHILD, 8'h00);
    send_load(9'd3, hwd_pkg::NO_CHILD, hwd_pkg::NO_CHILD, 8'hFF);
    send_load(9'd4, hwd_pkg::NO_CHILD, hwd_pkg::NO_CHILD, 8'h5A);
    send_load(9'd2, 9'd3, 9'd4, 8'h00);
    send_load(9'd0, 9'd1, 9'd2, 8'h81);
    // Top entry of the store: left goes to a leaf, right child missing
    send_load(9'd510, 9'd1, hwd_pkg::NO_CHILD, 8'hA5);
    // Load beyond the store is dropped
    send_load(OUT_OF_STORE, 9'd0, 9'd0, 8'hFF);
    // Walk sits at node 0 out of reset, so a byte decodes even without a start.
    // All zeros gives the maximum of eight symbols in one word.
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_word(MODE_UNUSED, 9'h1FF, 9'h1FF, 9'h1FF, 8'hFF, 8'hFF, 1'b1);
    send_start();
    send_byte(8'hB6, 1'b0);

    // Symbol limit reached inside a byte: rest of the bits dropped, then sticky
    wait_idle();
    write_reg(hwd_pkg::REG_EXPECTED, 32'd3);
    send_start();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);

    // Maximum padding: a final byte carries only its top bit
    wait_idle();
    write_reg(hwd_pkg::REG_EXPECTED, 32'd0);
    write_reg(hwd_pkg::REG_PAD, 32'd7);
    send_start();
    send_byte(8'h80, 1'b1);
    send_byte(8'h7F, 1'b1);

    // Highest legal root, then a missing child breaks the stream (sticky)
    wait_idle();
    write_reg(hwd_pkg::REG_ROOT, 32'd510);
    send_start();
    send_byte(8'h40, 1'b0);
    send_byte(8'h00, 1'b0);

    // Root outside the store: first bit breaks
    wait_idle();
    write_reg(hwd_pkg::REG_ROOT, 32'd511);
    send_start();
    send_byte(8'hA5, 1'b0);

    wait_idle();
    write_reg(hwd_pkg::REG_ROOT, 32'd0);
    write_reg(hwd_pkg::REG_PAD, 32'd0);
    write_reg(hwd_pkg::REG_EXPECTED, 32'hFFFF_FFFF);
    send_start();
    send_byte(8'h5A, 1'b0);

    // ---- Random streams ----
    // Each stream: load a fresh tree, set the registers while idle, start, then a
    // run of random bytes with occasional noise words. Phases rotate the traffic.
    while (words_sent < TARGET_WORDS) begin
      case (streams % 4)
        0: begin idle_pct = 0;  stall_pct <= 0;  end
        1: begin idle_pct = 77; stall_pct <= 0;  end
        2: begin idle_pct = 0;  stall_pct <= 77; end
        default: begin idle_pct = 25; stall_pct <= 25; end
      endcase

      build_tree($urandom_range(6, 2), tree_root);
      // Sometimes damage the tree: half-leaves, missing children, loops
      if ($urandom_range(4) == 0)
        send_load(pick_loaded(), pick_child(), pick_child(), 8'($urandom_range(255)));

      // Sender pauses until every result is back before reprogramming
      wait_idle();
      case ($urandom_range(19))
        0:       write_reg(hwd_pkg::REG_ROOT, 32'd510);
        1:       write_reg(hwd_pkg::REG_ROOT, 32'd511);
        default: write_reg(hwd_pkg::REG_ROOT, 32'(tree_root));
      endcase
      if ($urandom_range(1)) write_reg(hwd_pkg::REG_PAD, 32'($urandom_range(7)));
      if ($urandom_range(1)) begin
        case ($urandom_range(3))
          0:       write_reg(hwd_pkg::REG_EXPECTED, 32'd0);
          1:       write_reg(hwd_pkg::REG_EXPECTED, 32'($urandom));
          default: write_reg(hwd_pkg::REG_EXPECTED, 32'($urandom_range(24, 1)));
        endcase
      end
      // Now and then skip the start so the walk carries over from the last stream
      if ($urandom_range(9) != 0) send_start();

      if (streams % 5 == 2) hold_tickets <= hold_tickets + 1;

      nbytes = $urandom_range(12, 3);
      for (int i = 0; i < nbytes; i++) begin
        noise = $urandom_range(19);
        if (noise == 0)
          send_word(MODE_UNUSED, 9'($urandom_range(511)), 9'($urandom_range(511)),
                    9'($urandom_range(511)), 8'($urandom_range(255)),
                    8'($urandom_range(255)), 1'($urandom_range(1)));
        else if (noise == 1)
          send_load(OUT_OF_STORE, pick_child(), pick_child(), 8'($urandom_range(255)));
        else if (noise == 2)
          send_load(pick_loaded(), pick_child(), pick_child(), 8'($urandom_range(255)));
        else if (noise == 3)
          send_start();
        send_byte(8'($urandom_range(255)), (i == nbytes - 1) || ($urandom_range(9) == 0));
      end
      streams++;
    end

    // ---- Drain and verdict ----
    inp_ch.valid <= 1'b0;
    @(posedge clk);
    guard = 0;
    while (pending != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (40) @(posedge clk);

    $display("Run covered %0d input words over %0d random streams plus the directed tree,",
             words_sent, streams);
    $display("and checked %0d result words carrying %0d decoded symbols.",
             words_out, symbols_out);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      if (pending != 0) $error("%0d expected result words never arrived", pending);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
